### rtl/assert_macros.svh
// assertion macros for the decoder rtl
// expects signals named clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define VGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, checked out of reset
`define VGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define VGM_ASSERT_IMP(lbl, ante, cons)
`define VGM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/vgmcd_pkg.sv
// shared types and constants for the command stream decoder
// no dependencies
`default_nettype none

package vgmcd_pkg;

  // result kinds
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_WAIT     = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // opcodes
  localparam logic [7:0] OP_END        = 8'h66;
  localparam logic [7:0] OP_REG_WRITE  = 8'hB4;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
  localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
  localparam logic [3:0] OP_SHORT_WAIT_HI = 4'h7;

  localparam logic [15:0] SAMPLES_NTSC = 16'd735;
  localparam logic [15:0] SAMPLES_PAL  = 16'd882;

  localparam logic [14:0] CHIP_BASE    = 15'h4000;
  localparam logic [31:0] CPS_RESET    = 32'd340446805;
  localparam logic [20:0] WAIT_MAX     = 21'h1FFFFF;

  // input word
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_of_stream;
    logic       last_of_stream;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [14:0] chip_address;
    logic [7:0]  write_value;
    logic [20:0] wait_cycles;
    logic        stream_done;
  } out_word_t;

  // decoded step from parser to the wait-scaling stage
  typedef struct packed {
    logic        has_result;
    logic [1:0]  kind;
    logic [14:0] addr;
    logic [7:0]  value;
    logic [15:0] samples;
    logic        done;
  } step_t;

endpackage

`default_nettype wire

### rtl/vgm_apu_command_decoder.sv
// Command stream decoder for a sound-log byte stream.
// Input channel in_valid/in_ready/in_word: one stream byte per word, with
// first/last markers. First word of a stream clears any halt and parse state.
// Output channel out_valid/out_ready/out_word: at most one result per byte
// (register write, wait scaled from samples to CPU time, finished, or error).
// Config: cfg_we/cfg_data writes the Q8.24 cycles-per-sample register at once;
// write it only while the decoder is idle.
// A byte that completes a command passes through the parse register, then
// the output register behind the wait multiply, before its result shows on
// out_word.
// Throughput: one byte per cycle while the receiver keeps up.
// The wait scaling is one 16x32 multiply between the two pipeline registers.
// When out_ready is low, the output register holds and one more result may
// wait in the parse register; in_ready drops only when both are full, and
// then every byte waits, whether or not it gives a result.
// After a stream-ending result (finished, error, or any from the last word)
// the decoder drops bytes until a word marked first_of_stream arrives.
// Reset (rst_n low, synchronous) empties the pipeline, clears the parse
// state and restores cycles_per_sample to its default.
// depends on vgmcd_pkg, vgmcd_parser and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vgm_apu_command_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vgmcd_pkg::in_word_t in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vgmcd_pkg::out_word_t     out_word,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data
);

  logic              in_accept;
  logic              advance;
  vgmcd_pkg::step_t  step;
  vgmcd_pkg::step_t  s1_step_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  vgmcd_pkg::out_word_t out_word_r, out_word_nxt;
  logic [31:0]       cps_r;
  logic [47:0]       product;
  logic [20:0]       wait_sat;

  // handshake: parse register drains into the output register
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  vgmcd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .word   (in_word),
    .step   (step)
  );

  // cycles per sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r <= vgmcd_pkg::CPS_RESET;
    end else if (cfg_we) begin
      cps_r <= cfg_data;
    end
  end

  // parse register valid
  always_comb begin
    if (in_accept && step.has_result) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step.has_result) begin
      s1_step_r <= step;
    end
  end

  // wait scaling: samples times Q8.24, floor, saturate to 21 bits
  assign product  = {32'd0, s1_step_r.samples} * {16'd0, cps_r};
  assign wait_sat = (|product[47:45]) ? vgmcd_pkg::WAIT_MAX : product[44:24];

  always_comb begin
    out_word_nxt.result_kind  = s1_step_r.kind;
    out_word_nxt.chip_address = s1_step_r.addr;
    out_word_nxt.write_value  = s1_step_r.value;
    out_word_nxt.wait_cycles  = wait_sat;
    out_word_nxt.stream_done  = s1_step_r.done;
  end

  // output register
  assign out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `VGM_ASSERT_IMP(a_wait_only_on_wait,
    out_valid_r && (out_word_r.result_kind != vgmcd_pkg::KIND_WAIT),
    out_word_r.wait_cycles == 21'd0)
  `VGM_ASSERT_IMP(a_end_kinds_done,
    out_valid_r && ((out_word_r.result_kind == vgmcd_pkg::KIND_ERROR) ||
                    (out_word_r.result_kind == vgmcd_pkg::KIND_FINISHED)),
    out_word_r.stream_done)
  `VGM_ASSERT_IMP(a_write_addr_base,
    out_valid_r && (out_word_r.result_kind == vgmcd_pkg::KIND_WRITE),
    out_word_r.chip_address[14])
  `VGM_ASSERT_NXT(a_s1_holds_on_stall, s1_valid_r && !advance, s1_valid_r)

endmodule

`default_nettype wire

### rtl/vgmcd_parser.sv
// byte-level command parser: parse state registers and one-byte decode step
// depends on vgmcd_pkg
`default_nettype none

module vgmcd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire vgmcd_pkg::in_word_t word,
  output vgmcd_pkg::step_t         step
);

  // parse phase codes
  localparam logic [3:0] PH_OPCODE     = 4'd0;
  localparam logic [3:0] PH_WR_ADDR    = 4'd1;
  localparam logic [3:0] PH_WR_VAL     = 4'd2;
  localparam logic [3:0] PH_WAIT_LO    = 4'd3;
  localparam logic [3:0] PH_WAIT_HI    = 4'd4;
  localparam logic [3:0] PH_BLK_COMPAT = 4'd5;
  localparam logic [3:0] PH_BLK_TYPE   = 4'd6;
  localparam logic [3:0] PH_BLK_SIZE   = 4'd7;
  localparam logic [3:0] PH_BLK_SKIP   = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        halted_r, halted_nxt;

  logic [3:0]  ph;
  logic [7:0]  held;
  logic [31:0] remain;
  logic [1:0]  idx;
  logic        hlt;
  logic [7:0]  b;
  logic        last;
  logic [31:0] assembled;
  logic [31:0] decremented;
  vgmcd_pkg::step_t res;

  assign b    = word.stream_byte;
  assign last = word.last_of_stream;

  // decode one byte against the current parse state
  always_comb begin
    ph     = phase_r;
    held   = held_r;
    remain = remain_r;
    idx    = idx_r;
    hlt    = halted_r;
    // first byte of a stream restarts the parse
    if (word.first_of_stream) begin
      ph     = PH_OPCODE;
      held   = 8'd0;
      remain = 32'd0;
      idx    = 2'd0;
      hlt    = 1'b0;
    end
    phase_nxt  = ph;
    held_nxt   = held;
    remain_nxt = remain;
    idx_nxt    = idx;
    halted_nxt = hlt;

    res            = '0;
    res.kind       = vgmcd_pkg::KIND_WRITE;
    assembled      = remain | ({24'd0, b} << {idx, 3'b000});
    decremented    = remain - 32'd1;

    if (!hlt) begin
      case (ph)
        PH_WR_ADDR, PH_WAIT_LO: begin
          held_nxt = b;
          if (last) begin
            phase_nxt      = PH_OPCODE;
            res.has_result = 1'b1;
            res.kind       = vgmcd_pkg::KIND_ERROR;
            res.done       = 1'b1;
          end else begin
            phase_nxt = (ph == PH_WR_ADDR) ? PH_WR_VAL : PH_WAIT_HI;
          end
        end
        PH_WR_VAL: begin
          phase_nxt      = PH_OPCODE;
          res.has_result = 1'b1;
          res.kind       = vgmcd_pkg::KIND_WRITE;
          res.addr       = vgmcd_pkg::CHIP_BASE + {7'd0, held};
          res.value      = b;
          res.done       = last;
        end
        PH_WAIT_HI: begin
          phase_nxt      = PH_OPCODE;
          res.has_result = 1'b1;
          res.kind       = vgmcd_pkg::KIND_WAIT;
          res.samples    = {b, held};
          res.done       = last;
        end
        PH_BLK_COMPAT, PH_BLK_TYPE: begin
          if (last) begin
            phase_nxt      = PH_OPCODE;
            res.has_result = 1'b1;
            res.kind       = vgmcd_pkg::KIND_ERROR;
            res.done       = 1'b1;
          end else if (ph == PH_BLK_COMPAT) begin
            phase_nxt = PH_BLK_TYPE;
          end else begin
            phase_nxt  = PH_BLK_SIZE;
            idx_nxt    = 2'd0;
            remain_nxt = 32'd0;
          end
        end
        PH_BLK_SIZE: begin
          remain_nxt = assembled;
          if (idx == 2'd3) begin
            idx_nxt = 2'd0;
            if (assembled == 32'd0) begin
              // empty block ends here
              phase_nxt = PH_OPCODE;
              if (last) begin
                res.has_result = 1'b1;
                res.kind       = vgmcd_pkg::KIND_FINISHED;
                res.done       = 1'b1;
              end
            end else if (last) begin
              phase_nxt      = PH_OPCODE;
              res.has_result = 1'b1;
              res.kind       = vgmcd_pkg::KIND_ERROR;
              res.done       = 1'b1;
            end else begin
              phase_nxt = PH_BLK_SKIP;
            end
          end else begin
            idx_nxt = idx + 2'd1;
            if (last) begin
              phase_nxt      = PH_OPCODE;
              res.has_result = 1'b1;
              res.kind       = vgmcd_pkg::KIND_ERROR;
              res.done       = 1'b1;
            end
          end
        end
        PH_BLK_SKIP: begin
          remain_nxt = decremented;
          if (decremented == 32'd0) begin
            phase_nxt = PH_OPCODE;
            if (last) begin
              res.has_result = 1'b1;
              res.kind       = vgmcd_pkg::KIND_FINISHED;
              res.done       = 1'b1;
            end
          end else if (last) begin
            phase_nxt      = PH_OPCODE;
            res.has_result = 1'b1;
            res.kind       = vgmcd_pkg::KIND_ERROR;
            res.done       = 1'b1;
          end
        end
        default: begin
          // opcode byte
          phase_nxt = PH_OPCODE;
          case (b)
            vgmcd_pkg::OP_END: begin
              res.has_result = 1'b1;
              res.kind       = vgmcd_pkg::KIND_FINISHED;
              res.done       = 1'b1;
            end
            vgmcd_pkg::OP_REG_WRITE, vgmcd_pkg::OP_WAIT_N,
            vgmcd_pkg::OP_DATA_BLOCK: begin
              if (last) begin
                res.has_result = 1'b1;
                res.kind       = vgmcd_pkg::KIND_ERROR;
                res.done       = 1'b1;
              end else if (b == vgmcd_pkg::OP_REG_WRITE) begin
                phase_nxt = PH_WR_ADDR;
              end else if (b == vgmcd_pkg::OP_WAIT_N) begin
                phase_nxt = PH_WAIT_LO;
              end else begin
                phase_nxt = PH_BLK_COMPAT;
              end
            end
            vgmcd_pkg::OP_WAIT_NTSC, vgmcd_pkg::OP_WAIT_PAL: begin
              res.has_result = 1'b1;
              res.kind       = vgmcd_pkg::KIND_WAIT;
              res.samples    = (b == vgmcd_pkg::OP_WAIT_NTSC) ?
                               vgmcd_pkg::SAMPLES_NTSC : vgmcd_pkg::SAMPLES_PAL;
              res.done       = last;
            end
            default: begin
              res.has_result = 1'b1;
              res.done       = 1'b1;
              if (b[7:4] == vgmcd_pkg::OP_SHORT_WAIT_HI) begin
                res.kind    = vgmcd_pkg::KIND_WAIT;
                res.samples = {12'd0, b[3:0]} + 16'd1;
                res.done    = last;
              end else begin
                res.kind    = vgmcd_pkg::KIND_ERROR;
              end
            end
          endcase
        end
      endcase
    end

    // any stream-ending result halts until the next first word
    if (res.has_result && res.done) begin
      halted_nxt = 1'b1;
    end
  end

  assign step = res;

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      held_r   <= 8'd0;
      remain_r <= 32'd0;
      idx_r    <= 2'd0;
      halted_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      remain_r <= remain_nxt;
      idx_r    <= idx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking bench for the command stream decoder: a queue-fed driver,
// a monitor and a bit-exact decode model of each stream word
// depends on vgmcd_pkg and vgm_apu_command_decoder
`timescale 1ns / 100ps

module tb_top;
  import vgmcd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  // parse states of the decode model
  typedef enum logic [3:0] {
    ST_OPCODE, ST_WR_ADDR, ST_WR_VAL, ST_WAIT_LO, ST_WAIT_HI,
    ST_BLK_COMPAT, ST_BLK_TYPE, ST_BLK_SIZE, ST_BLK_SKIP
  } parse_st_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  // stimulus and scoreboard state
  in_word_t    stream_words[$];
  out_word_t   decoded_results[$];
  logic [7:0]  cmd_bytes[$];
  int          words_queued = 0;
  int          words_sent = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          in_fire = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_on = 1'b0;

  // decode model state
  parse_st_t   parse_st = ST_OPCODE;
  logic [7:0]  held_q = '0;
  logic [31:0] skip_left = '0;
  logic [1:0]  size_idx = '0;
  bit          halted = 1'b0;
  logic [31:0] cps = CPS_RESET;

  vgm_apu_command_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // result word; any word that ends the stream halts the parser
  function automatic out_word_t pack_result(logic [1:0] kind, logic [14:0] addr,
                                            logic [7:0] val, logic [20:0] cyc, bit done);
    out_word_t r;
    r.result_kind  = kind;
    r.chip_address = addr;
    r.write_value  = val;
    r.wait_cycles  = cyc;
    r.stream_done  = done;
    if (done) halted = 1'b1;
    return r;
  endfunction

  function automatic out_word_t end_result(logic [1:0] kind);
    parse_st = ST_OPCODE;
    return pack_result(kind, '0, '0, '0, 1'b1);
  endfunction

  // samples times Q8.24 cycles per sample, floored and saturated
  function automatic out_word_t wait_result(logic [15:0] samples, bit done);
    logic [63:0] prod;
    logic [63:0] cyc;
    prod = 64'(samples) * 64'(cps);
    cyc = prod >> 24;
    if (cyc > 64'(WAIT_MAX)) cyc = 64'(WAIT_MAX);
    parse_st = ST_OPCODE;
    return pack_result(KIND_WAIT, '0, '0, cyc[20:0], done);
  endfunction

  // one accepted stream word; returns 1 when it completes a result
  function automatic bit decode_stream_byte(input in_word_t w, output out_word_t r);
    logic [7:0] b;
    bit is_last;
    b = w.stream_byte;
    is_last = w.last_of_stream;
    r = '0;
    if (w.first_of_stream) begin
      halted = 1'b0;
      parse_st = ST_OPCODE;
      held_q = '0;
      skip_left = '0;
      size_idx = '0;
    end
    if (halted) return 1'b0;
    case (parse_st)
      ST_WR_ADDR, ST_WAIT_LO: begin
        held_q = b;
        if (is_last) begin
          r = end_result(KIND_ERROR);
          return 1'b1;
        end
        parse_st = (parse_st == ST_WR_ADDR) ? ST_WR_VAL : ST_WAIT_HI;
        return 1'b0;
      end
      ST_WR_VAL: begin
        parse_st = ST_OPCODE;
        r = pack_result(KIND_WRITE, CHIP_BASE + 15'(held_q), b, '0, is_last);
        return 1'b1;
      end
      ST_WAIT_HI: begin
        r = wait_result({b, held_q}, is_last);
        return 1'b1;
      end
      ST_BLK_COMPAT, ST_BLK_TYPE: begin
        if (is_last) begin
          r = end_result(KIND_ERROR);
          return 1'b1;
        end
        if (parse_st == ST_BLK_TYPE) begin
          size_idx = '0;
          skip_left = '0;
          parse_st = ST_BLK_SIZE;
        end else begin
          parse_st = ST_BLK_TYPE;
        end
        return 1'b0;
      end
      ST_BLK_SIZE: begin
        skip_left = skip_left | (32'(b) << (8 * size_idx));
        if (size_idx == 2'd3) begin
          size_idx = '0;
          // zero-length block is complete at its header
          if (skip_left == '0) begin
            parse_st = ST_OPCODE;
            if (is_last) begin
              r = end_result(KIND_FINISHED);
              return 1'b1;
            end
            return 1'b0;
          end
          if (is_last) begin
            r = end_result(KIND_ERROR);
            return 1'b1;
          end
          parse_st = ST_BLK_SKIP;
          return 1'b0;
        end
        size_idx = size_idx + 2'd1;
        if (is_last) begin
          r = end_result(KIND_ERROR);
          return 1'b1;
        end
        return 1'b0;
      end
      ST_BLK_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) begin
          parse_st = ST_OPCODE;
          if (is_last) begin
            r = end_result(KIND_FINISHED);
            return 1'b1;
          end
          return 1'b0;
        end
        if (is_last) begin
          r = end_result(KIND_ERROR);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
      end
    endcase

    // opcode byte
    parse_st = ST_OPCODE;
    case (b)
      OP_END: begin
        r = end_result(KIND_FINISHED);
        return 1'b1;
      end
      OP_REG_WRITE, OP_WAIT_N, OP_DATA_BLOCK: begin
        if (is_last) begin
          r = end_result(KIND_ERROR);
          return 1'b1;
        end
        parse_st = (b == OP_REG_WRITE) ? ST_WR_ADDR :
                   (b == OP_WAIT_N)    ? ST_WAIT_LO : ST_BLK_COMPAT;
        return 1'b0;
      end
      OP_WAIT_NTSC: begin
        r = wait_result(SAMPLES_NTSC, is_last);
        return 1'b1;
      end
      OP_WAIT_PAL: begin
        r = wait_result(SAMPLES_PAL, is_last);
        return 1'b1;
      end
      default: begin
        if (b[7:4] == OP_SHORT_WAIT_HI) r = wait_result(16'(b[3:0]) + 16'd1, is_last);
        else r = end_result(KIND_ERROR);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, out_word_t e, out_word_t a);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t mismatch (%s): exp k=%0d a=%h v=%h c=%0d d=%0d, got k=%0d a=%h v=%h c=%0d d=%0d",
               $realtime, what, e.result_kind, e.chip_address, e.write_value,
               e.wait_cycles, e.stream_done, a.result_kind, a.chip_address,
               a.write_value, a.wait_cycles, a.stream_done);
  endtask

  // monitor: check results, then predict from the accepted word
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t pred_w;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          report_mismatch("unexpected", '0, out_word);
        end else begin
          exp_w = decoded_results.pop_front();
          if (exp_w.result_kind !== out_word.result_kind ||
              exp_w.chip_address !== out_word.chip_address ||
              exp_w.write_value !== out_word.write_value ||
              exp_w.wait_cycles !== out_word.wait_cycles ||
              exp_w.stream_done !== out_word.stream_done)
            report_mismatch("field", exp_w, out_word);
        end
      end
      if (in_valid && in_ready) begin
        words_sent <= words_sent + 1;
        if (decode_stream_byte(in_word, pred_w)) decoded_results.push_back(pred_w);
      end
    end
  end

  // driver: next word once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (stream_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= stream_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready with random gaps and the long hold-off
  always @(negedge clk) begin
    out_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off so the pipeline fills and stalls the input
  initial begin
    wait (hold_req);
    repeat (20) @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(logic [7:0] b, bit first, bit is_last);
    in_word_t w;
    w.stream_byte = b;
    w.first_of_stream = first;
    w.last_of_stream = is_last;
    stream_words.push_back(w);
    words_queued++;
  endtask

  task automatic flush_stream(bit mark_last);
    foreach (cmd_bytes[i])
      send_word(cmd_bytes[i], i == 0, mark_last && (i == cmd_bytes.size() - 1));
    cmd_bytes.delete();
  endtask

  // one command with random content, mostly well-formed
  task automatic push_cmd();
    int sel;
    int n;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 28) begin
      cmd_bytes.push_back(OP_REG_WRITE);
      cmd_bytes.push_back(8'($urandom));
      cmd_bytes.push_back(8'($urandom));
    end else if (sel < 42) begin
      cmd_bytes.push_back(OP_WAIT_N);
      cmd_bytes.push_back(8'($urandom));
      cmd_bytes.push_back(8'($urandom));
    end else if (sel < 49) begin
      cmd_bytes.push_back(OP_WAIT_NTSC);
    end else if (sel < 56) begin
      cmd_bytes.push_back(OP_WAIT_PAL);
    end else if (sel < 72) begin
      cmd_bytes.push_back({OP_SHORT_WAIT_HI, 4'($urandom)});
    end else if (sel < 88) begin
      n = $urandom_range(0, 4);
      cmd_bytes.push_back(OP_DATA_BLOCK);
      cmd_bytes.push_back(8'($urandom));
      cmd_bytes.push_back(8'($urandom));
      cmd_bytes.push_back(8'(n));
      repeat (3) cmd_bytes.push_back(8'h00);
      repeat (n) cmd_bytes.push_back(8'($urandom));
    end else if (sel < 94) begin
      cmd_bytes.push_back(OP_END);
    end else begin
      // opcode outside the command set
      do b = 8'($urandom);
      while (b == OP_END || b == OP_REG_WRITE || b == OP_WAIT_N || b == OP_WAIT_NTSC ||
             b == OP_WAIT_PAL || b == OP_DATA_BLOCK || b[7:4] == OP_SHORT_WAIT_HI);
      cmd_bytes.push_back(b);
    end
  endtask

  // mostly well-formed streams, some cut short, some junk
  task automatic fill_random(int target);
    int start;
    int sel;
    start = words_queued;
    while (words_queued - start < target) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        repeat ($urandom_range(1, 6)) push_cmd();
        sel = $urandom_range(9);
        if (sel < 4) cmd_bytes.push_back(OP_END);
        flush_stream(sel < 8);
      end else if (sel < 84) begin
        // stream with up to two trailing bytes dropped, often cut inside a command
        repeat ($urandom_range(1, 4)) push_cmd();
        repeat ($urandom_range(1, 2))
          if (cmd_bytes.size() > 1) void'(cmd_bytes.pop_back());
        flush_stream(1'b1);
      end else if (sel < 91) begin
        // data block too long to finish before the stream ends
        cmd_bytes.push_back(OP_DATA_BLOCK);
        repeat (5) cmd_bytes.push_back(8'($urandom));
        cmd_bytes.push_back(8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 5)) cmd_bytes.push_back(8'($urandom));
        flush_stream($urandom_range(1));
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
      end
    end
  endtask

  // all words taken, all results seen, pipeline empty
  task automatic wait_idle();
    while (!(words_sent == words_queued && decoded_results.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cps(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    cps = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // test sequence
  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 78;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: field extremes and every opcode at the reset rate
    send_word(OP_REG_WRITE, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(OP_REG_WRITE, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(OP_WAIT_N, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(OP_WAIT_NTSC, 1'b0, 1'b0);
    send_word(OP_WAIT_PAL, 1'b0, 1'b0);
    send_word({OP_SHORT_WAIT_HI, 4'h0}, 1'b0, 1'b0);
    // last word completing a wait ends the stream
    send_word({OP_SHORT_WAIT_HI, 4'hF}, 1'b0, 1'b1);
    // data block whose final skipped word is the last
    send_word(OP_DATA_BLOCK, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h01, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    // end command, then a word dropped while halted
    send_word(OP_END, 1'b1, 1'b0);
    send_word(OP_WAIT_NTSC, 1'b0, 1'b0);
    // unknown opcode, then a write cut short by the last word
    send_word(8'h05, 1'b1, 1'b0);
    send_word(OP_REG_WRITE, 1'b1, 1'b1);
    wait_idle();

    // largest rate: long waits saturate; receiver holds off for a while
    write_cps(32'hFFFF_FFFF);
    @(posedge clk);
    fill_random(350);
    hold_req = 1'b1;
    wait_idle();

    // zero rate, idling the other way round
    send_idle_pct = 78;
    recv_idle_pct = 19;
    write_cps(32'h0000_0000);
    @(posedge clk);
    fill_random(300);
    wait_idle();

    // random rate, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cps($urandom);
    @(posedge clk);
    fill_random(350);
    wait_idle();

    if (fail_count == 0 && decoded_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
